// ===== design/wav_header_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// WAV header parser assertion macros
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WAV_HEADER_PARSER_UNIT_ASSERT_SVH
`define WAV_HEADER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define WAVHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavhp assertion failed");

// next-cycle implication
`define WAVHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavhp assertion failed");

`endif

// ===== design/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV header parser package
// Beat types, parser states, status codes and chunk mark constants.
// ----------------------------------------------------------------------------
package wavhp_pkg;

  localparam int unsigned HdrLenW = 40;

  localparam logic [HdrLenW-1:0] HDR_LEN_MAX   = {HdrLenW{1'b1}};
  localparam logic [31:0]        MARK_FACT     = 32'h6661_6374;
  localparam logic [31:0]        MARK_LIST     = 32'h6C69_7374;
  localparam logic [31:0]        MARK_DATA     = 32'h6461_7461;
  localparam logic [31:0]        FMT_BASE_SIZE = 32'd16;

  // byte positions inside the fixed header parts
  localparam logic [4:0] RIFF_LAST_IDX = 5'd11;
  localparam logic [4:0] FMT_LAST_IDX  = 5'd23;
  localparam logic [4:0] SIZE_LAST_IDX = 5'd7;
  localparam logic [4:0] WORD_LAST_IDX = 5'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FMT_SHORT = 2'd1,
    ST_BAD_MARK  = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_RIFF  = 8'b0000_0010,
    PH_FMT   = 8'b0000_0100,
    PH_SKIP  = 8'b0000_1000,
    PH_MARK  = 8'b0001_0000,
    PH_CLEN  = 8'b0010_0000,
    PH_DSIZE = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       start_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               size_mismatch;
    logic [15:0]        audio_fmt;
    logic [15:0]        channel_count;
    logic [31:0]        samples_per_sec;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        bits_per_sample;
    logic [31:0]        data_size;
    logic [HdrLenW-1:0] header_length;
  } out_beat_t;

  // ASCII upper case to lower case, byte by byte
  function automatic logic [31:0] lower_mark(logic [31:0] m);
    logic [31:0] r;
    logic [7:0]  c;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      c = m[8*i +: 8];
      if (c >= 8'h41 && c <= 8'h5A) begin
        c = c + 8'h20;
      end
      r[8*i +: 8] = c;
    end
    return r;
  endfunction

endpackage

// ===== design/wavhp_core.sv =====
// ----------------------------------------------------------------------------
// WAV header parser core
// Per-byte parse state machine; flags a result in the cycle of its last byte.
// ----------------------------------------------------------------------------
module wavhp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_en,
  input  wavhp_pkg::in_beat_t  beat,
  output logic                 res_valid,
  output wavhp_pkg::out_beat_t res
);

  wavhp_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [4:0]  idx_r, idx_nxt, cur_idx, idx_inc;
  logic [wavhp_pkg::HdrLenW-1:0] cons_r, cons_nxt, cur_cons, cons_inc;
  logic [31:0] word_r, word_nxt, word_shift;
  logic [31:0] riff_r, riff_nxt;
  logic [31:0] fmtsz_r, fmtsz_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] mark_r, mark_nxt, mark_shift, mark_low;
  logic [63:0] f0_r, f0_nxt, f1_r, f1_nxt;
  logic [wavhp_pkg::HdrLenW:0] total;
  logic [7:0]  b;
  logic [1:0]  status;
  logic        mism;
  logic [31:0] dsize;

  assign b          = beat.stream_byte;
  assign cur_phase  = beat.start_of_stream ? wavhp_pkg::PH_RIFF : phase_r;
  assign cur_idx    = beat.start_of_stream ? 5'd0 : idx_r;
  assign cur_cons   = beat.start_of_stream ? '0 : cons_r;
  assign cons_inc   = (cur_cons != wavhp_pkg::HDR_LEN_MAX) ? cur_cons + 1'b1 : cur_cons;
  assign idx_inc    = cur_idx + 5'd1;
  assign word_shift = {b, word_r[31:8]};
  assign mark_shift = {mark_r[23:0], b};
  assign mark_low   = wavhp_pkg::lower_mark(mark_shift);
  // data size + header length - 8, compared against the RIFF size
  assign total      = {9'd0, word_shift} + {1'b0, cons_inc} - 41'd8;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    cons_nxt  = cons_r;
    word_nxt  = word_r;
    riff_nxt  = riff_r;
    fmtsz_nxt = fmtsz_r;
    skip_nxt  = skip_r;
    mark_nxt  = mark_r;
    f0_nxt    = f0_r;
    f1_nxt    = f1_r;
    res_valid = 1'b0;
    status    = wavhp_pkg::ST_OK;
    mism      = 1'b0;
    dsize     = '0;
    if (beat_en) begin
      phase_nxt = cur_phase;
      idx_nxt   = cur_idx;
      cons_nxt  = cur_cons;
      unique case (cur_phase)
        wavhp_pkg::PH_RIFF: begin
          cons_nxt = cons_inc;
          if (cur_idx >= 5'd4 && cur_idx <= wavhp_pkg::SIZE_LAST_IDX) begin
            word_nxt = word_shift;
          end
          if (cur_idx == wavhp_pkg::SIZE_LAST_IDX) begin
            riff_nxt = word_shift;
          end
          if (cur_idx == wavhp_pkg::RIFF_LAST_IDX) begin
            phase_nxt = wavhp_pkg::PH_FMT;
            idx_nxt   = 5'd0;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        wavhp_pkg::PH_FMT: begin
          cons_nxt = cons_inc;
          idx_nxt  = idx_inc;
          if (cur_idx >= 5'd4 && cur_idx <= wavhp_pkg::SIZE_LAST_IDX) begin
            word_nxt = word_shift;
          end
          if (cur_idx == wavhp_pkg::SIZE_LAST_IDX) begin
            fmtsz_nxt = word_shift;
          end
          if (cur_idx >= 5'd8 && cur_idx <= 5'd15) begin
            f0_nxt[8*cur_idx[2:0] +: 8] = b;
          end
          if (cur_idx >= 5'd16 && cur_idx <= wavhp_pkg::FMT_LAST_IDX) begin
            f1_nxt[8*cur_idx[2:0] +: 8] = b;
          end
          if (cur_idx == wavhp_pkg::FMT_LAST_IDX) begin
            if (fmtsz_r < wavhp_pkg::FMT_BASE_SIZE) begin
              res_valid = 1'b1;
              status    = wavhp_pkg::ST_FMT_SHORT;
              phase_nxt = wavhp_pkg::PH_DONE;
            end else begin
              skip_nxt  = fmtsz_r - wavhp_pkg::FMT_BASE_SIZE;
              idx_nxt   = 5'd0;
              if (fmtsz_r == wavhp_pkg::FMT_BASE_SIZE) begin
                phase_nxt = wavhp_pkg::PH_MARK;
              end else begin
                phase_nxt = wavhp_pkg::PH_SKIP;
              end
            end
          end
        end
        wavhp_pkg::PH_SKIP: begin
          cons_nxt = cons_inc;
          if (skip_r != 32'd0) begin
            skip_nxt = skip_r - 32'd1;
          end
          if (skip_r <= 32'd1) begin
            phase_nxt = wavhp_pkg::PH_MARK;
            idx_nxt   = 5'd0;
          end
        end
        wavhp_pkg::PH_MARK: begin
          cons_nxt = cons_inc;
          mark_nxt = mark_shift;
          idx_nxt  = idx_inc;
          if (cur_idx == wavhp_pkg::WORD_LAST_IDX) begin
            idx_nxt = 5'd0;
            if (mark_low == wavhp_pkg::MARK_FACT || mark_low == wavhp_pkg::MARK_LIST) begin
              phase_nxt = wavhp_pkg::PH_CLEN;
            end else if (mark_shift == wavhp_pkg::MARK_DATA) begin
              phase_nxt = wavhp_pkg::PH_DSIZE;
            end else begin
              res_valid = 1'b1;
              status    = wavhp_pkg::ST_BAD_MARK;
              phase_nxt = wavhp_pkg::PH_DONE;
            end
          end
        end
        wavhp_pkg::PH_CLEN: begin
          cons_nxt = cons_inc;
          word_nxt = word_shift;
          idx_nxt  = idx_inc;
          if (cur_idx == wavhp_pkg::WORD_LAST_IDX) begin
            skip_nxt  = word_shift;
            idx_nxt   = 5'd0;
            if (word_shift == 32'd0) begin
              phase_nxt = wavhp_pkg::PH_MARK;
            end else begin
              phase_nxt = wavhp_pkg::PH_SKIP;
            end
          end
        end
        wavhp_pkg::PH_DSIZE: begin
          cons_nxt = cons_inc;
          word_nxt = word_shift;
          idx_nxt  = idx_inc;
          if (cur_idx == wavhp_pkg::WORD_LAST_IDX) begin
            res_valid = 1'b1;
            status    = wavhp_pkg::ST_OK;
            mism      = (total != {9'd0, riff_r});
            dsize     = word_shift;
            phase_nxt = wavhp_pkg::PH_DONE;
          end
        end
        wavhp_pkg::PH_IDLE, wavhp_pkg::PH_DONE: begin
          phase_nxt = cur_phase;
        end
        default: begin
          phase_nxt = wavhp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.status          = status;
    res.size_mismatch   = mism;
    res.audio_fmt       = f0_nxt[15:0];
    res.channel_count   = f0_nxt[31:16];
    res.samples_per_sec = f0_nxt[63:32];
    res.byte_rate       = f1_nxt[31:0];
    res.block_align     = f1_nxt[47:32];
    res.bits_per_sample = f1_nxt[63:48];
    res.data_size       = dsize;
    res.header_length   = cons_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wavhp_pkg::PH_IDLE;
      idx_r   <= 5'd0;
      cons_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      cons_r  <= cons_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    riff_r  <= riff_nxt;
    fmtsz_r <= fmtsz_nxt;
    skip_r  <= skip_nxt;
    mark_r  <= mark_nxt;
    f0_r    <= f0_nxt;
    f1_r    <= f1_nxt;
  end

endmodule

// ===== design/wav_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// WAV header parser unit
// Parses RIFF/WAVE headers from a byte stream and reports format and sizes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one file byte per beat; start_of_stream marks byte 0 of a new file
//           and restarts the parse from any state.
//   out_* : one result beat per file: status, fmt fields, data size and the
//           header length up to the end of the data chunk header or the byte that ends the parse.
//   Throughput: one byte per cycle while in_ready is high. Each byte goes
//   through the parse state machine in the cycle it is accepted.
//   Result: valid in the cycle after the beat of the byte that ends the
//   parse (last data size byte, last fmt byte, or a bad mark).
//   Bytes before the first start or after a result are consumed and dropped.
//   Stalls: the result sits in the output register; in_ready stays high while
//   it is empty or being taken this cycle, so a waiting result blocks input
//   only while out_ready is low.
//   Reset: synchronous; the parser goes idle and the output register empties.
//   A stream that ends early produces no result.
// ----------------------------------------------------------------------------
module wav_header_parser_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wavhp_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wavhp_pkg::out_beat_t out_data
);

  logic                 beat_en;
  logic                 res_valid;
  wavhp_pkg::out_beat_t res;
  logic                 out_valid_r, out_valid_nxt;
  wavhp_pkg::out_beat_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign beat_en  = in_valid && in_ready;

  wavhp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_en   (beat_en),
    .beat      (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/wavhp_checker.sv =====
// ----------------------------------------------------------------------------
// WAV header parser port checker
// Watches the result channel for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "wav_header_parser_unit_assert.svh"

module wavhp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input wavhp_pkg::out_beat_t out_data
);

  // a stalled result beat holds
  `WAVHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // status stays within the defined codes
  `WAVHP_ASSERT_NOW(a_status_legal, out_valid, out_data.status <= wavhp_pkg::ST_BAD_MARK)

  // error results carry no size check
  `WAVHP_ASSERT_NOW(a_err_no_mism,
    out_valid && out_data.status != wavhp_pkg::ST_OK, !out_data.size_mismatch)

  // short fmt block ends right after the 36 fixed bytes
  `WAVHP_ASSERT_NOW(a_fmt_short_len,
    out_valid && out_data.status == wavhp_pkg::ST_FMT_SHORT, out_data.header_length == 40'd36)

  // a good parse covers at least RIFF, fmt and data headers
  `WAVHP_ASSERT_NOW(a_ok_min_len,
    out_valid && out_data.status == wavhp_pkg::ST_OK, out_data.header_length >= 40'd44)

endmodule

bind wav_header_parser_unit wavhp_checker u_wavhp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Feeds RIFF/WAVE byte streams (well-formed, short fmt, bad marks, truncated,
// restarted, noise) and checks every header report against a byte-level
// parser model with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  wavhp_pkg::in_beat_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wavhp_pkg::out_beat_t out_data;

  wav_header_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // parser model state
  wavhp_pkg::phase_t  ph;
  logic [4:0]         byte_pos;
  logic [31:0]        skip_left;
  logic [31:0]        word_acc;
  logic [31:0]        riff_size;
  logic [31:0]        fmt_size;
  logic [63:0]        fmt_lo;
  logic [63:0]        fmt_hi;
  logic [wavhp_pkg::HdrLenW-1:0] consumed;
  logic [31:0]        mark_acc;

  wavhp_pkg::out_beat_t pending_headers[$];
  logic [7:0]  img[$];
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned headers_checked = 0;
  int unsigned n_ok = 0, n_short = 0, n_bad = 0, n_sizediff = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d headers still pending", cycles,
               pending_headers.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: ~9% stalls unless in a calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] ascii_lower32(logic [31:0] m);
    logic [31:0] r;
    r = m;
    for (int k = 0; k < 32; k += 8) begin
      if (r[k +: 8] inside {[8'h41 : 8'h5A]}) r[k +: 8] = r[k +: 8] | 8'h20;
    end
    return r;
  endfunction

  task automatic reset_parser();
    ph = wavhp_pkg::PH_IDLE;
    byte_pos = '0;
    skip_left = '0;
    word_acc = '0;
    riff_size = '0;
    fmt_size = '0;
    fmt_lo = '0;
    fmt_hi = '0;
    consumed = '0;
    mark_acc = '0;
  endtask

  task automatic enter_chunk_walk();
    ph = (skip_left != 0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_MARK;
    byte_pos = '0;
    mark_acc = '0;
  endtask

  task automatic report_header(wavhp_pkg::status_t st, logic diff, logic [31:0] dsize);
    wavhp_pkg::out_beat_t r;
    r.status          = st;
    r.size_mismatch   = diff;
    r.audio_fmt       = fmt_lo[15:0];
    r.channel_count   = fmt_lo[31:16];
    r.samples_per_sec = fmt_lo[63:32];
    r.byte_rate       = fmt_hi[31:0];
    r.block_align     = fmt_hi[47:32];
    r.bits_per_sample = fmt_hi[63:48];
    r.data_size       = dsize;
    r.header_length   = consumed;
    pending_headers.push_back(r);
    ph = wavhp_pkg::PH_DONE;
    case (st)
      wavhp_pkg::ST_OK:        n_ok++;
      wavhp_pkg::ST_FMT_SHORT: n_short++;
      default:                 n_bad++;
    endcase
    if (diff) n_sizediff++;
  endtask

  task automatic parse_wav_byte(wavhp_pkg::in_beat_t beat);
    logic [7:0]  b;
    logic [63:0] total;
    logic [31:0] low;
    b = beat.stream_byte;
    if (beat.start_of_stream) begin
      reset_parser();
      ph = wavhp_pkg::PH_RIFF;
    end
    if (ph == wavhp_pkg::PH_IDLE || ph == wavhp_pkg::PH_DONE) return;
    if (consumed != wavhp_pkg::HDR_LEN_MAX) consumed++;
    case (ph)
      wavhp_pkg::PH_RIFF: begin
        if (byte_pos >= 4 && byte_pos <= wavhp_pkg::SIZE_LAST_IDX) begin
          word_acc = {b, word_acc[31:8]};
          if (byte_pos == wavhp_pkg::SIZE_LAST_IDX) riff_size = word_acc;
        end
        if (byte_pos == wavhp_pkg::RIFF_LAST_IDX) begin
          ph = wavhp_pkg::PH_FMT;
          byte_pos = '0;
        end else begin
          byte_pos++;
        end
      end
      wavhp_pkg::PH_FMT: begin
        if (byte_pos >= 4 && byte_pos <= wavhp_pkg::SIZE_LAST_IDX) begin
          word_acc = {b, word_acc[31:8]};
          if (byte_pos == wavhp_pkg::SIZE_LAST_IDX) fmt_size = word_acc;
        end else if (byte_pos >= 8 && byte_pos <= 15) begin
          fmt_lo[8*(byte_pos-8) +: 8] = b;
        end else if (byte_pos >= 16) begin
          fmt_hi[8*(byte_pos-16) +: 8] = b;
        end
        if (byte_pos == wavhp_pkg::FMT_LAST_IDX) begin
          if (fmt_size < wavhp_pkg::FMT_BASE_SIZE) begin
            report_header(wavhp_pkg::ST_FMT_SHORT, 1'b0, '0);
          end else begin
            skip_left = fmt_size - wavhp_pkg::FMT_BASE_SIZE;
            enter_chunk_walk();
          end
        end else begin
          byte_pos++;
        end
      end
      wavhp_pkg::PH_SKIP: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) enter_chunk_walk();
      end
      wavhp_pkg::PH_MARK: begin
        mark_acc = {mark_acc[23:0], b};
        if (byte_pos == wavhp_pkg::WORD_LAST_IDX) begin
          byte_pos = '0;
          word_acc = '0;
          low = ascii_lower32(mark_acc);
          if (low == wavhp_pkg::MARK_FACT || low == wavhp_pkg::MARK_LIST)
            ph = wavhp_pkg::PH_CLEN;
          else if (mark_acc == wavhp_pkg::MARK_DATA)
            ph = wavhp_pkg::PH_DSIZE;
          else
            report_header(wavhp_pkg::ST_BAD_MARK, 1'b0, '0);
        end else begin
          byte_pos++;
        end
      end
      wavhp_pkg::PH_CLEN: begin
        word_acc = {b, word_acc[31:8]};
        if (byte_pos == wavhp_pkg::WORD_LAST_IDX) begin
          skip_left = word_acc;
          enter_chunk_walk();
        end else begin
          byte_pos++;
        end
      end
      wavhp_pkg::PH_DSIZE: begin
        word_acc = {b, word_acc[31:8]};
        if (byte_pos == wavhp_pkg::WORD_LAST_IDX) begin
          // no wrap: riff size must match the exact sum
          total = 64'(word_acc) + 64'(consumed) - 64'd8;
          report_header(wavhp_pkg::ST_OK, total != 64'(riff_size), word_acc);
        end else begin
          byte_pos++;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    wavhp_pkg::out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_headers.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_headers.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("size_mismatch", want.size_mismatch, out_data.size_mismatch);
        check_field("audio_fmt", want.audio_fmt, out_data.audio_fmt);
        check_field("channel_count", want.channel_count, out_data.channel_count);
        check_field("samples_per_sec", want.samples_per_sec, out_data.samples_per_sec);
        check_field("byte_rate", want.byte_rate, out_data.byte_rate);
        check_field("block_align", want.block_align, out_data.block_align);
        check_field("bits_per_sample", want.bits_per_sample, out_data.bits_per_sample);
        check_field("data_size", want.data_size, out_data.data_size);
        check_field("header_length", want.header_length, out_data.header_length);
        headers_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic sos);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{stream_byte: b, start_of_stream: sos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_wav_byte('{stream_byte: b, start_of_stream: sos});
    bytes_sent++;
  endtask

  task automatic send_file(int n);
    for (int i = 0; i < n; i++) send_byte(img[i], i == 0);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_headers.size() != 0) @(posedge clk);
  endtask

  task automatic put_word(logic [31:0] w);
    for (int k = 0; k < 32; k += 8) img.push_back(w[k +: 8]);
  endtask

  // marks go out in text order
  task automatic put_mark(logic [31:0] m);
    for (int k = 24; k >= 0; k -= 8) img.push_back(m[k +: 8]);
  endtask

  task automatic put_rand(int n);
    repeat (n) img.push_back(8'($urandom));
  endtask

  task automatic start_file(logic [31:0] riff);
    img.delete();
    put_mark("RIFF");
    put_word(riff);
    put_mark("WAVE");
  endtask

  task automatic put_fmt(logic [31:0] fsz, logic [127:0] fields);
    put_mark("fmt ");
    put_word(fsz);
    for (int k = 0; k < 128; k += 8) img.push_back(fields[k +: 8]);
  endtask

  task automatic put_chunk(logic [31:0] m, int len);
    put_mark(m);
    put_word(32'(len));
    put_rand(len);
  endtask

  // consistent riff size for the header built so far (wraps at 32 bits)
  task automatic fix_riff(logic [31:0] dsize);
    logic [31:0] r;
    r = dsize + 32'(img.size()) - 32'd8;
    for (int k = 0; k < 4; k++) img[4+k] = r[8*k +: 8];
  endtask

  function automatic logic [31:0] mixed_case(logic [31:0] m);
    logic [31:0] r;
    r = m;
    for (int k = 0; k < 32; k += 8) begin
      if ($urandom_range(0, 1)) r[k +: 8] = r[k +: 8] & 8'hDF;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_bytes_before_start();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
  endtask

  task automatic test_plain_pcm();
    start_file('0);
    put_fmt(32'd16, {16'd16, 16'd4, 32'd176400, 32'd44100, 16'd2, 16'd1});
    put_mark("data");
    put_word(32'd1000);
    fix_riff(32'd1000);
    put_rand(3);  // trailing audio, ignored
    send_file(img.size());
  endtask

  task automatic test_fmt_too_short();
    start_file(32'h1234_5678);
    put_fmt(32'd15, {$urandom, $urandom, $urandom, $urandom});
    send_file(img.size());
    start_file(32'hFFFF_FFFF);
    put_fmt(32'd0, '1);
    put_mark("data");
    send_file(img.size());
  endtask

  task automatic test_chunk_walk();
    start_file(32'd7);  // deliberately wrong riff size
    put_fmt(32'd18, {$urandom, $urandom, $urandom, $urandom});
    put_rand(2);
    put_chunk("FaCt", 0);
    put_chunk("LIST", 5);
    put_chunk("list", 1);
    put_mark("data");
    put_word(32'd0);
    send_file(img.size());
  endtask

  task automatic test_bad_marks();
    start_file('0);
    put_fmt(32'd16, '0);
    put_mark("DATA");  // data mark is matched exactly
    put_word(32'd4);
    send_file(img.size());
    start_file('0);
    put_fmt(32'd17, '1);
    put_rand(1);
    put_chunk("fact", 4);
    put_mark("junk");
    send_file(img.size());
  endtask

  task automatic test_restart_midway();
    start_file('0);
    put_fmt(32'd16, {$urandom, $urandom, $urandom, $urandom});
    send_file(20);
    put_chunk("fact", 2);
    send_file(img.size());  // stream stops before the next mark, no report
    start_file('0);
    put_fmt(32'd16, {$urandom, $urandom, $urandom, $urandom});
    put_mark("data");
    put_word(32'd44);
    fix_riff(32'd44);
    send_file(img.size());
  endtask

  task automatic test_field_extremes();
    start_file('0);
    put_fmt(32'd16, '1);
    put_mark("data");
    put_word(32'hFFFF_FFFF);
    fix_riff(32'hFFFF_FFFF);  // wrapped riff: exact sum differs
    send_file(img.size());
    start_file(32'hFFFF_FFFF);
    put_fmt(32'd16, '0);
    put_mark("data");
    put_word(32'd0);
    send_file(img.size());
  endtask

  task automatic random_file();
    int          kind, nchunks, r;
    logic [31:0] fsz, dsize, tail;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      // noise with a start flag in front
      img.delete();
      put_rand($urandom_range(1, 60));
      send_file(img.size());
      return;
    end
    start_file($urandom);
    r = $urandom_range(0, 99);
    if (r < 8)       fsz = $urandom_range(0, 15);
    else if (r < 35) fsz = 16 + $urandom_range(1, 8);
    else             fsz = 16;
    put_fmt(fsz, {$urandom, $urandom, $urandom, $urandom});
    if (fsz > 16) put_rand(fsz - 16);
    if (fsz >= 16) begin
      nchunks = ($urandom_range(0, 1)) ? 0 : $urandom_range(1, 3);
      repeat (nchunks) begin
        put_chunk(mixed_case($urandom_range(0, 1) ? wavhp_pkg::MARK_FACT
                                                  : wavhp_pkg::MARK_LIST),
                  $urandom_range(0, 10));
      end
      r = $urandom_range(0, 99);
      case (1'b1)
        r < 85: tail = wavhp_pkg::MARK_DATA;
        r < 90: tail = mixed_case(wavhp_pkg::MARK_DATA) & 32'hDFFF_FFFF;
        r < 95: tail = {wavhp_pkg::MARK_DATA[31:8], 8'($urandom)};
        default: tail = $urandom;
      endcase
      put_mark(tail);
      dsize = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 64)) : $urandom;
      put_word(dsize);
      if ($urandom_range(0, 99) < 70) fix_riff(dsize);
    end
    if ($urandom_range(0, 99) < 8) begin
      send_file($urandom_range(1, img.size() - 1));
    end else begin
      put_rand($urandom_range(0, 3));
      send_file(img.size());
    end
  endtask

  task automatic test_random_files();
    int unsigned files;
    files = 0;
    while (bytes_sent < 1800) begin
      calm = (files >= 12 && files < 20);
      random_file();
      files++;
      // sender holds off until all reports are back
      if (files % 13 == 0) wait_drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bytes_before_start();
    test_plain_pcm();
    test_fmt_too_short();
    test_chunk_walk();
    test_bad_marks();
    test_restart_midway();
    test_field_extremes();
    test_random_files();
    wait_drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d byte beats, %0d header reports checked", bytes_sent, headers_checked);
    $display("  reports: %0d ok, %0d short fmt, %0d bad mark, %0d with size mismatch",
             n_ok, n_short, n_bad, n_sizediff);
    if (mismatches == 0 && pending_headers.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/wavhp_pkg.sv
design/wavhp_core.sv
design/wav_header_parser_unit.sv
design/wavhp_checker.sv
dv/tb_top.sv
